// ===== hdl/bcfc_pkg.sv =====
// Package: shared constants and controller/datapath interface types
package bcfc_pkg;

	localparam int ROW_BYTES_DEF = 256;

	localparam logic [31:0] GUARD_VALUE      = 32'h2b620bc3;
	localparam logic [31:0] PAGE_BASE_MASK   = 32'hffffff00;
	localparam logic [7:0]  CMD_UNLOCK       = 8'ha0;
	localparam logic [7:0]  CMD_DATA         = 8'ha1;
	localparam logic [7:0]  CMD_VERIFY       = 8'ha2;
	localparam logic [7:0]  CMD_RESET        = 8'ha3;
	localparam logic [32:0] DATA_FLASH_BYTES = 33'd2048;
	localparam logic [32:0] SMALL_ROW_BYTES  = 33'd256;

	localparam logic [1:0] RESP_OK      = 2'd0;
	localparam logic [1:0] RESP_ERROR   = 2'd1;
	localparam logic [1:0] RESP_INVALID = 2'd2;

	localparam logic [1:0] KIND_NONE    = 2'd0;
	localparam logic [1:0] KIND_FLASH   = 2'd1;
	localparam logic [1:0] KIND_HANDOFF = 2'd2;
	localparam logic [1:0] KIND_VERIFY  = 2'd3;

	localparam int CFG_IW = 3;
	localparam logic [CFG_IW-1:0] REG_IDLE_TIMEOUT = 3'd0;
	localparam logic [CFG_IW-1:0] REG_MAIN_SIZE    = 3'd1;
	localparam logic [CFG_IW-1:0] REG_DATA_BASE    = 3'd2;
	localparam logic [CFG_IW-1:0] REG_USER_BASE    = 3'd3;
	localparam logic [CFG_IW-1:0] REG_BOOT_BASE    = 3'd4;

	localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd100;
	localparam logic [31:0] MAIN_SIZE_RST    = 32'd65536;
	localparam logic [31:0] DATA_BASE_RST    = 32'd4194304;
	localparam logic [31:0] USER_BASE_RST    = 32'd8404992;
	localparam logic [31:0] BOOT_BASE_RST    = 32'd8437760;

	typedef struct packed {
		logic accept;
		logic exec;
		logic rd_first;
		logic rd_next;
		logic load_word;
	} bcfc_cmd_t;

	typedef struct packed {
		logic fire;
		logic single;
		logic last_out;
	} bcfc_status_t;

endpackage

// ===== hdl/bcfc_ctrl.sv =====
// Controller: sequences byte intake, command execution and result beats
module bcfc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	input  bcfc_pkg::bcfc_status_t st,
	output bcfc_pkg::bcfc_cmd_t    cmd
);
	import bcfc_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_LOAD = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				in_ready   = 1'b1;
				cmd.accept = in_valid;
				if (in_valid && st.fire) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				cmd.exec = 1'b1;
				if (st.single) begin
					state_d = S_OUT;
				end else begin
					cmd.rd_first = 1'b1;
					state_d      = S_LOAD;
				end
			end
			S_LOAD: begin
				cmd.load_word = 1'b1;
				state_d       = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (st.last_out) begin
						state_d = S_IDLE;
					end else begin
						cmd.rd_next = 1'b1;
						state_d     = S_LOAD;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== hdl/bcfc_dp.sv =====
// Datapath: framing, payload store, command checks, window and result registers
module bcfc_dp #(
	parameter int ROW_BYTES = bcfc_pkg::ROW_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  bcfc_pkg::bcfc_cmd_t          cmd,
	output bcfc_pkg::bcfc_status_t       st,
	input  logic                        req_type,
	input  logic [7:0]                  rx_byte,
	input  logic                        cfg_valid,
	input  logic [bcfc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]                 cfg_data,
	output logic                        resp_valid,
	output logic [1:0]                  resp_code,
	output logic [1:0]                  word_kind,
	output logic [31:0]                 word_addr,
	output logic [31:0]                 word_data,
	output logic [31:0]                 verify_length,
	output logic                        reset_request,
	output logic                        last
);
	import bcfc_pkg::*;

	localparam int STORE_WORDS = 2 + ROW_BYTES / 4;
	localparam int AW          = $clog2(STORE_WORDS);
	localparam int BPW         = $clog2(8 + ROW_BYTES + 1);
	localparam int N_WORDS     = ROW_BYTES / 4;
	localparam int IW          = $clog2(N_WORDS);
	localparam logic [BPW-1:0] LEN_UNLOCK = BPW'(12);
	localparam logic [BPW-1:0] LEN_DATA   = BPW'(8 + ROW_BYTES);
	localparam logic [BPW-1:0] LEN_VERIFY = BPW'(8);
	localparam logic [BPW-1:0] LEN_RESET  = BPW'(20);
	localparam logic [IW-1:0]  IDX_DATA_LAST  = IW'(N_WORDS - 1);
	localparam logic [IW-1:0]  IDX_RESET_LAST = IW'(3);
	localparam logic [32:0]    ROW_SPAN       = 33'(ROW_BYTES);

	logic [15:0]    timeout_q;
	logic [31:0]    main_size_q, data_base_q, user_base_q, boot_base_q;
	logic [7:0]     cur_cmd_q, exec_cmd_q;
	logic [BPW-1:0] bp_q, exp_q, exp_open;
	logic [15:0]    idle_q, idle_next;
	logic [23:0]    acc_q;
	logic [31:0]    w0_q, w1_q, w2_q;
	logic [31:0]    wb_q, we_q;
	logic [31:0]    mem [STORE_WORDS];
	logic [31:0]    rdata_q;
	logic [AW-1:0]  ptr_q, rd_addr, wr_addr;
	logic [31:0]    wr_word;
	logic           wr_en;
	logic [IW-1:0]  idx_q;
	logic           run_data_q;
	logic           open_c, fire_c;

	logic        guard_ok, unlock_pass, data_pass, dec_single, dec_run_data;
	logic [32:0] ue;
	logic [1:0]  s_code, s_kind;
	logic        s_rv;
	logic [31:0] s_addr, s_data, s_vlen;
	logic        fin;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q   <= IDLE_TIMEOUT_RST;
			main_size_q <= MAIN_SIZE_RST;
			data_base_q <= DATA_BASE_RST;
			user_base_q <= USER_BASE_RST;
			boot_base_q <= BOOT_BASE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IDLE_TIMEOUT: timeout_q   <= cfg_data[15:0];
				REG_MAIN_SIZE:    main_size_q <= cfg_data;
				REG_DATA_BASE:    data_base_q <= cfg_data;
				REG_USER_BASE:    user_base_q <= cfg_data;
				REG_BOOT_BASE:    boot_base_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (rx_byte)
			CMD_UNLOCK: exp_open = LEN_UNLOCK;
			CMD_DATA:   exp_open = LEN_DATA;
			CMD_VERIFY: exp_open = LEN_VERIFY;
			CMD_RESET:  exp_open = LEN_RESET;
			default:    exp_open = '0;
		endcase
	end

	assign open_c    = (cur_cmd_q == 8'd0);
	assign fire_c    = !req_type && (open_c ? (exp_open == '0 && rx_byte != 8'd0)
	                                        : (bp_q + BPW'(1) == exp_q));
	assign idle_next = (idle_q != 16'hffff) ? idle_q + 16'd1 : idle_q;
	assign wr_addr   = AW'(bp_q >> 2);
	assign wr_word   = {rx_byte, acc_q};
	assign wr_en     = cmd.accept && !req_type && !open_c && (bp_q < exp_q)
	                   && (bp_q[1:0] == 2'd3);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_cmd_q  <= '0;
			exec_cmd_q <= '0;
			bp_q       <= '0;
			exp_q      <= '0;
			idle_q     <= '0;
			w0_q       <= '0;
		end else if (cmd.accept) begin
			if (req_type) begin
				idle_q <= idle_next;
				if (idle_next >= timeout_q) begin
					cur_cmd_q <= '0;
				end
			end else begin
				idle_q <= '0;
				if (open_c) begin
					bp_q  <= '0;
					exp_q <= exp_open;
					w0_q  <= '0;
					cur_cmd_q <= fire_c ? 8'd0 : rx_byte;
					if (fire_c) begin
						exec_cmd_q <= rx_byte;
					end
				end else begin
					if (bp_q < exp_q) begin
						bp_q <= bp_q + BPW'(1);
						if (wr_en && wr_addr == AW'(0)) begin
							w0_q <= wr_word;
						end
					end
					if (fire_c) begin
						cur_cmd_q  <= '0;
						exec_cmd_q <= cur_cmd_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept && !req_type && !open_c && bp_q < exp_q) begin
			acc_q <= {rx_byte, acc_q[23:8]};
		end
		if (wr_en && wr_addr == AW'(1)) begin
			w1_q <= wr_word;
		end
		if (wr_en && wr_addr == AW'(2)) begin
			w2_q <= wr_word;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
	end

	assign guard_ok = (w0_q == GUARD_VALUE);
	assign ue       = {1'b0, w1_q} + {1'b0, w2_q};

	always_comb begin
		unlock_pass = ((w1_q & ~PAGE_BASE_MASK) == 32'd0)
		              && ((w2_q & ~PAGE_BASE_MASK) == 32'd0)
		              && !ue[32] && (ue > {1'b0, w1_q})
		              && ((ue <= {1'b0, main_size_q})
		                  || ({1'b0, w1_q} >= {1'b0, data_base_q}
		                      && ue <= {1'b0, data_base_q} + DATA_FLASH_BYTES)
		                  || ({1'b0, w1_q} >= {1'b0, user_base_q}
		                      && ue <= {1'b0, user_base_q} + SMALL_ROW_BYTES)
		                  || ({1'b0, w1_q} >= {1'b0, boot_base_q}
		                      && ue <= {1'b0, boot_base_q} + SMALL_ROW_BYTES));
		data_pass = (wb_q <= w1_q) && ({1'b0, w1_q} + ROW_SPAN <= {1'b0, we_q});
	end

	always_comb begin
		dec_single   = 1'b1;
		dec_run_data = 1'b0;
		s_rv         = 1'b1;
		s_code       = RESP_INVALID;
		s_kind       = KIND_NONE;
		s_addr       = '0;
		s_data       = '0;
		s_vlen       = '0;
		if (guard_ok) begin
			case (exec_cmd_q)
				CMD_UNLOCK: begin
					s_code = unlock_pass ? RESP_OK : RESP_ERROR;
				end
				CMD_DATA: begin
					if (data_pass) begin
						dec_single   = 1'b0;
						dec_run_data = 1'b1;
					end else begin
						s_code = RESP_ERROR;
					end
				end
				CMD_VERIFY: begin
					if (we_q > wb_q) begin
						s_rv   = 1'b0;
						s_code = RESP_OK;
						s_kind = KIND_VERIFY;
						s_addr = wb_q;
						s_data = w1_q;
						s_vlen = we_q - wb_q;
					end
				end
				CMD_RESET: begin
					dec_single = 1'b0;
				end
				default: begin
				end
			endcase
		end
	end

	assign rd_addr = cmd.rd_first ? (dec_run_data ? AW'(2) : AW'(1)) : ptr_q + AW'(1);

	always_ff @(posedge clk) begin
		if (cmd.rd_first || cmd.rd_next) begin
			rdata_q <= mem[rd_addr];
			ptr_q   <= rd_addr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= '0;
			we_q <= '0;
		end else if (cmd.exec && guard_ok && exec_cmd_q == CMD_UNLOCK) begin
			wb_q <= unlock_pass ? w1_q : 32'd0;
			we_q <= unlock_pass ? ue[31:0] : 32'd0;
		end
	end

	assign fin = run_data_q ? (idx_q == IDX_DATA_LAST) : (idx_q == IDX_RESET_LAST);

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			run_data_q <= dec_run_data;
			idx_q      <= '0;
			if (dec_single) begin
				resp_valid    <= s_rv;
				resp_code     <= s_code;
				word_kind     <= s_kind;
				word_addr     <= s_addr;
				word_data     <= s_data;
				verify_length <= s_vlen;
				reset_request <= 1'b0;
				last          <= 1'b1;
			end
		end else if (cmd.load_word) begin
			idx_q         <= idx_q + IW'(1);
			resp_valid    <= fin;
			resp_code     <= RESP_OK;
			word_kind     <= run_data_q ? KIND_FLASH : KIND_HANDOFF;
			word_addr     <= run_data_q ? w1_q + 32'({idx_q, 2'b00}) : 32'(idx_q);
			word_data     <= rdata_q;
			verify_length <= '0;
			reset_request <= fin && !run_data_q;
			last          <= fin;
		end
	end

	assign st.fire     = fire_c;
	assign st.single   = dec_single;
	assign st.last_out = last;

endmodule

// ===== hdl/boot_command_frame_checker.sv =====
// Top level: boot command frame checker, controller plus datapath
// Input beats are taken only while idle; idle ticks and non-final bytes give no result.
// A frame-completing byte registers the command, checked in the execute state, where a
// single result is registered; data and reset runs read each word from the payload
// store and load it in the load state. Input is held off until the last beat is taken.
// Asynchronous reset clears control state, the window and registers to defaults.
module boot_command_frame_checker #(
	parameter int ROW_BYTES = bcfc_pkg::ROW_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic                        req_type,
	input  logic [7:0]                  rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic                        resp_valid,
	output logic [1:0]                  resp_code,
	output logic [1:0]                  word_kind,
	output logic [31:0]                 word_addr,
	output logic [31:0]                 word_data,
	output logic [31:0]                 verify_length,
	output logic                        reset_request,
	output logic                        last,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [bcfc_pkg::CFG_IW-1:0] cfg_index,
	input  logic [31:0]                 cfg_data
);
	import bcfc_pkg::*;

	bcfc_cmd_t    cmd;
	bcfc_status_t st;

	assign cfg_ready = 1'b1;

	bcfc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.st        (st),
		.cmd       (cmd)
	);

	bcfc_dp #(
		.ROW_BYTES (ROW_BYTES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.req_type      (req_type),
		.rx_byte       (rx_byte),
		.cfg_valid     (cfg_valid),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.resp_valid    (resp_valid),
		.resp_code     (resp_code),
		.word_kind     (word_kind),
		.word_addr     (word_addr),
		.word_data     (word_data),
		.verify_length (verify_length),
		.reset_request (reset_request),
		.last          (last)
	);

endmodule

// ===== hdl/bcfc_checker.sv =====
// Checker: port-level assertions for the boot command frame checker, with bind
module bcfc_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic       resp_valid,
	input logic [1:0] word_kind,
	input logic       reset_request,
	input logic       last
);
	import bcfc_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result beat dropped before acceptance");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while a result beat is pending");

	a_silent_word: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !resp_valid |-> word_kind != KIND_NONE)
		else $error("beat with neither response nor word");

	a_reset_final: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && reset_request |-> last && resp_valid && word_kind == KIND_HANDOFF)
		else $error("reset request off the final handoff beat");

	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && word_kind == KIND_NONE |-> last && resp_valid)
		else $error("plain response not marked last");

endmodule

bind boot_command_frame_checker bcfc_checker u_bcfc_checker (.*);

// ===== tb/boot_command_frame_checker_tb.sv =====
// Testbench for the boot command frame checker: framed command stimulus, predicted results
module boot_command_frame_checker_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import bcfc_pkg::*;

	typedef struct packed {
		logic        resp_valid;
		logic [1:0]  resp_code;
		logic [1:0]  word_kind;
		logic [31:0] word_addr;
		logic [31:0] word_data;
		logic [31:0] verify_length;
		logic        reset_request;
		logic        last;
	} result_t;

	localparam int ROWB = ROW_BYTES_DEF;
	localparam int ROW_WORDS = ROWB / 4;
	localparam int STORE_WORDS = 2 + ROW_WORDS;

	class frame_scoreboard;
		logic [15:0] timeout_ticks;
		logic [31:0] main_size, data_base, user_base, boot_base;
		logic [7:0]  open_cmd;
		logic [8:0]  byte_ptr, frame_len;
		logic [31:0] store [STORE_WORDS];
		logic [31:0] win_lo, win_hi;
		logic [15:0] idle_cnt;
		result_t     pending [$];
		int          errors;

		function new();
			timeout_ticks = IDLE_TIMEOUT_RST;
			main_size = MAIN_SIZE_RST;
			data_base = DATA_BASE_RST;
			user_base = USER_BASE_RST;
			boot_base = BOOT_BASE_RST;
			open_cmd = 8'h00;
			byte_ptr = '0;
			frame_len = '0;
			foreach (store[i]) store[i] = '0;
			win_lo = '0;
			win_hi = '0;
			idle_cnt = '0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
			case (idx)
				REG_IDLE_TIMEOUT: timeout_ticks = val[15:0];
				REG_MAIN_SIZE:    main_size = val;
				REG_DATA_BASE:    data_base = val;
				REG_USER_BASE:    user_base = val;
				REG_BOOT_BASE:    boot_base = val;
				default: ;
			endcase
		endfunction

		function void push(logic rv, logic [1:0] rc, logic [1:0] kind, logic [31:0] addr,
				logic [31:0] data, logic [31:0] vlen, logic rst, logic lst);
			result_t r;
			r.resp_valid = rv;
			r.resp_code = rc;
			r.word_kind = kind;
			r.word_addr = addr;
			r.word_data = data;
			r.verify_length = vlen;
			r.reset_request = rst;
			r.last = lst;
			pending.push_back(r);
		endfunction

		function bit within_region(logic [32:0] b, logic [32:0] e, logic [31:0] base,
				logic [32:0] size);
			return b >= {1'b0, base} && e <= {1'b0, base} + size;
		endfunction

		function void run_command();
			logic [31:0] b, s;
			logic [32:0] e;
			bit ok;
			if (store[0] != GUARD_VALUE) begin
				push(1'b1, RESP_INVALID, KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
				return;
			end
			case (open_cmd)
				CMD_UNLOCK: begin
					b = store[1];
					s = store[2];
					e = {1'b0, b} + {1'b0, s};
					ok = (b & ~PAGE_BASE_MASK) == 0 && (s & ~PAGE_BASE_MASK) == 0 && !e[32]
						&& e > {1'b0, b}
						&& (e <= {1'b0, main_size}
						|| within_region({1'b0, b}, e, data_base, DATA_FLASH_BYTES)
						|| within_region({1'b0, b}, e, user_base, SMALL_ROW_BYTES)
						|| within_region({1'b0, b}, e, boot_base, SMALL_ROW_BYTES));
					win_lo = ok ? b : '0;
					win_hi = ok ? e[31:0] : '0;
					push(1'b1, ok ? RESP_OK : RESP_ERROR, KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
				end
				CMD_DATA: begin
					b = store[1];
					e = {1'b0, b} + 33'(ROWB);
					if (!(win_lo <= b && e <= {1'b0, win_hi}))
						push(1'b1, RESP_ERROR, KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
					else
						for (int i = 0; i < ROW_WORDS; i++)
							push(i == ROW_WORDS - 1, RESP_OK, KIND_FLASH, b + 32'(4 * i),
								store[2 + i], '0, 1'b0, i == ROW_WORDS - 1);
				end
				CMD_VERIFY: begin
					if (win_hi > win_lo)
						push(1'b0, RESP_OK, KIND_VERIFY, win_lo, store[1], win_hi - win_lo,
							1'b0, 1'b1);
					else
						push(1'b1, RESP_INVALID, KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
				end
				CMD_RESET: begin
					for (int i = 0; i < 4; i++)
						push(i == 3, RESP_OK, KIND_HANDOFF, 32'(i), store[1 + i], '0,
							i == 3, i == 3);
				end
				default: push(1'b1, RESP_INVALID, KIND_NONE, '0, '0, '0, 1'b0, 1'b1);
			endcase
		endfunction

		function void note_beat(logic tick, logic [7:0] b);
			int w;
			if (tick) begin
				if (idle_cnt != 16'hffff) idle_cnt++;
				if (idle_cnt >= timeout_ticks) open_cmd = 8'h00;
				return;
			end
			idle_cnt = '0;
			if (open_cmd == 8'h00) begin
				byte_ptr = '0;
				open_cmd = b;
				store[0] = '0;
				case (b)
					CMD_UNLOCK: frame_len = 9'd12;
					CMD_DATA:   frame_len = 9'(8 + ROWB);
					CMD_VERIFY: frame_len = 9'd8;
					CMD_RESET:  frame_len = 9'd20;
					default:    frame_len = '0;
				endcase
			end else if (byte_ptr < frame_len) begin
				w = int'(byte_ptr >> 2);
				if (w < STORE_WORDS) store[w][8 * byte_ptr[1:0] +: 8] = b;
				byte_ptr++;
			end
			if (byte_ptr == frame_len) begin
				if (open_cmd != 8'h00) run_command();
				open_cmd = 8'h00;
			end
		endfunction

		task report(string msg);
			$display("MISMATCH: %s", msg);
			errors++;
		endtask

		task check_result(result_t got);
			result_t want;
			if (pending.size() == 0) begin
				report($sformatf("unexpected result %p", got));
				return;
			end
			want = pending.pop_front();
			if (got.resp_valid !== want.resp_valid)
				report($sformatf("resp_valid %0b want %0b", got.resp_valid, want.resp_valid));
			if (got.resp_code !== want.resp_code)
				report($sformatf("resp_code %0d want %0d", got.resp_code, want.resp_code));
			if (got.word_kind !== want.word_kind)
				report($sformatf("word_kind %0d want %0d", got.word_kind, want.word_kind));
			if (got.word_addr !== want.word_addr)
				report($sformatf("word_addr %h want %h", got.word_addr, want.word_addr));
			if (got.word_data !== want.word_data)
				report($sformatf("word_data %h want %h", got.word_data, want.word_data));
			if (got.verify_length !== want.verify_length)
				report($sformatf("verify_length %h want %h", got.verify_length,
					want.verify_length));
			if (got.reset_request !== want.reset_request)
				report($sformatf("reset_request %0b want %0b", got.reset_request,
					want.reset_request));
			if (got.last !== want.last)
				report($sformatf("last %0b want %0b", got.last, want.last));
		endtask
	endclass

	logic clk, arst_n;
	logic in_valid, in_ready, req_type;
	logic [7:0] rx_byte;
	logic out_valid, out_ready;
	result_t got;
	logic cfg_valid, cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [31:0] cfg_data;

	frame_scoreboard sb;
	bit no_gaps;
	bit hold_req;
	int quiet_cycles = 0;

	boot_command_frame_checker dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .req_type(req_type), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.resp_valid(got.resp_valid), .resp_code(got.resp_code), .word_kind(got.word_kind),
		.word_addr(got.word_addr), .word_data(got.word_data),
		.verify_length(got.verify_length), .reset_request(got.reset_request),
		.last(got.last),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
	end

	// watchdog: cycles with no beat on any channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= 4000) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// result side: random stalls plus one long hold on request
	initial begin
		int stall;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (600) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				stall = no_gaps ? 0 : $urandom_range(0, 7);
				if (stall > 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			sb.check_result(got);
		end
	end

	task automatic send_beat(logic tick, logic [7:0] b);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= tick;
		rx_byte <= b;
		do @(posedge clk); while (!in_ready);
		sb.note_beat(tick, b);
	endtask

	task automatic send_ticks(int n);
		repeat (n) send_beat(1'b1, 8'($urandom));
	endtask

	// command byte, then words little-endian; cut short after keep bytes if keep >= 0
	task automatic send_frame(logic [7:0] cmd, logic [31:0] words[$], int keep, bit noisy);
		int sent;
		sent = 0;
		send_beat(1'b0, cmd);
		foreach (words[i])
			for (int k = 0; k < 4; k++) begin
				if (keep >= 0 && sent >= keep) return;
				if (noisy && $urandom_range(0, 63) == 0) send_beat(1'b1, 8'($urandom));
				send_beat(1'b0, words[i][8 * k +: 8]);
				sent++;
			end
	endtask

	task automatic write_reg(logic [CFG_IW-1:0] idx, logic [31:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		sb.set_reg(idx, val);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic set_all(logic [15:0] t, logic [31:0] ms, logic [31:0] db,
			logic [31:0] ub, logic [31:0] bb);
		drain();
		write_reg(REG_IDLE_TIMEOUT, 32'(t));
		write_reg(REG_MAIN_SIZE, ms);
		write_reg(REG_DATA_BASE, db);
		write_reg(REG_USER_BASE, ub);
		write_reg(REG_BOOT_BASE, bb);
	endtask

	task automatic unlock(logic [31:0] b, logic [31:0] s, bit bad_guard);
		logic [31:0] w[$];
		w = {bad_guard ? ~GUARD_VALUE : GUARD_VALUE, b, s};
		send_frame(CMD_UNLOCK, w, -1, 1'b0);
	endtask

	task automatic verify_cmd(logic [31:0] guard, logic [31:0] crc, bit noisy);
		logic [31:0] w[$];
		w = {guard, crc};
		send_frame(CMD_VERIFY, w, -1, noisy);
	endtask

	task automatic reset_cmd(logic [31:0] guard, bit noisy);
		logic [31:0] w[$];
		w = {guard};
		repeat (4) w.push_back($urandom);
		send_frame(CMD_RESET, w, -1, noisy);
	endtask

	task automatic data_row(logic [31:0] a, int keep, bit noisy);
		logic [31:0] w[$];
		w = {GUARD_VALUE, a};
		repeat (ROW_WORDS) w.push_back($urandom);
		send_frame(CMD_DATA, w, keep, noisy);
	endtask

	task automatic random_unlock();
		logic [31:0] b, s;
		int k;
		case ($urandom_range(0, 5))
			0, 1: begin
				if (sb.main_size >= 256) begin
					b = 256 * $urandom_range(0, (sb.main_size >> 8) - 1);
					k = (sb.main_size >> 8) - (b >> 8);
					s = 256 * $urandom_range(1, k > 8 ? 8 : k);
				end else begin
					b = 0;
					s = 256;
				end
			end
			2: begin
				k = $urandom_range(0, 7);
				b = sb.data_base + 256 * k;
				s = 256 * $urandom_range(1, 8 - k);
			end
			3: begin
				b = sb.user_base;
				s = 256;
			end
			4: begin
				b = sb.boot_base;
				s = 256;
			end
			default: begin
				b = $urandom;
				s = $urandom_range(0, 1) ? $urandom : 256 * $urandom_range(0, 4);
			end
		endcase
		unlock(b, s, $urandom_range(0, 11) == 0);
	endtask

	task automatic random_frames(int n);
		logic [31:0] w[$];
		repeat (n) begin
			no_gaps = $urandom_range(0, 4) == 0;
			case ($urandom_range(0, 11))
				0, 1, 2: random_unlock();
				3: begin
					if (sb.timeout_ticks <= 120) begin
						data_row($urandom, $urandom_range(0, 12), 1'b1);
						send_ticks(sb.timeout_ticks);
					end else begin
						verify_cmd(GUARD_VALUE, $urandom, 1'b1);
					end
				end
				4, 5: verify_cmd(GUARD_VALUE, $urandom, 1'b1);
				6: reset_cmd(GUARD_VALUE, 1'b1);
				7: send_beat(1'b0, 8'($urandom));
				8: send_ticks($urandom_range(1, 4));
				9: begin
					w = {GUARD_VALUE, $urandom, $urandom};
					send_frame(CMD_UNLOCK, w, $urandom_range(0, 10), 1'b0);
					send_ticks(sb.timeout_ticks > 120 ? $urandom_range(1, 3)
						: sb.timeout_ticks);
				end
				10: verify_cmd($urandom, $urandom, 1'b0);
				default: send_beat(1'b0, 8'(CMD_RESET + $urandom_range(1, 80)));
			endcase
		end
		no_gaps = 1'b0;
	endtask

	initial begin
		logic [31:0] wq[$];
		sb = new();
		in_valid = 1'b0;
		req_type = 1'b0;
		rx_byte = 8'h00;
		cfg_valid = 1'b0;
		cfg_index = REG_IDLE_TIMEOUT;
		cfg_data = '0;
		hold_req = 1'b0;
		no_gaps = 1'b0;
		@(posedge arst_n);
		@(posedge clk);

		verify_cmd(GUARD_VALUE, 32'h1234_5678, 1'b0);
		send_beat(1'b0, 8'h55);
		send_beat(1'b0, 8'h00);
		send_beat(1'b0, 8'hff);
		unlock(32'h0, 32'h400, 1'b1);
		unlock(32'h80, 32'h400, 1'b0);
		unlock(32'h0, 32'h400, 1'b0);
		data_row(32'h100, -1, 1'b0);
		verify_cmd(GUARD_VALUE, 32'hffff_ffff, 1'b0);
		wq = {GUARD_VALUE, 32'h0, 32'hffff_ffff, 32'ha5a5_5a5a, 32'h1};
		send_frame(CMD_RESET, wq, -1, 1'b0);
		send_beat(1'b0, 8'ha4);
		unlock(32'hffff_ff00, 32'h100, 1'b0);

		set_all(16'd1, 32'h0, 32'hffff_f800, 32'hffff_ff00, 32'h0);
		random_frames(6);

		set_all(16'hffff, 32'hffff_ffff, 32'($urandom) & PAGE_BASE_MASK,
			32'($urandom) & PAGE_BASE_MASK, 32'($urandom));
		random_frames(6);

		set_all(16'($urandom_range(2, 20)), 32'h0004_0000, DATA_BASE_RST, USER_BASE_RST,
			BOOT_BASE_RST);
		unlock(32'h0, 32'h1000, 1'b0);
		hold_req = 1'b1;
		no_gaps = 1'b1;
		reset_cmd(GUARD_VALUE, 1'b0);
		verify_cmd(GUARD_VALUE, $urandom, 1'b0);
		reset_cmd(GUARD_VALUE, 1'b0);
		no_gaps = 1'b0;
		random_frames(6);

		drain();
		if (sb.errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule

// ===== filelist.f =====
hdl/bcfc_pkg.sv
hdl/bcfc_ctrl.sv
hdl/bcfc_dp.sv
hdl/boot_command_frame_checker.sv
hdl/bcfc_checker.sv
tb/boot_command_frame_checker_tb.sv
